FILE: design/dmx_frame_diff_encoder_assert.svh
// ----------------------------------------------------------------------------
// dmx frame diff encoder assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef DMX_FRAME_DIFF_ENCODER_ASSERT_SVH
`define DMX_FRAME_DIFF_ENCODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dmx frame diff encoder: implication failed");

// next-cycle implication, disabled during reset
`define DFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dmx frame diff encoder: next-cycle check failed");

`endif

FILE: design/dmxfde_pkg.sv
// ----------------------------------------------------------------------------
// dmxfde_pkg
// types and constants of the dmx frame diff encoder
// ----------------------------------------------------------------------------
package dmxfde_pkg;

    localparam int CHANNEL_W = 10;
    localparam int VALUE_W   = 8;
    localparam int LIMIT_W   = 7;

    localparam logic [LIMIT_W-1:0] DIFF_LIMIT_RESET = 7'd64;

    typedef enum logic [2:0] {
        KIND_UNCHANGED = 3'd0,
        KIND_ENTRY     = 3'd1,
        KIND_EMPTY     = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_DROPPED   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] slot_value;
        logic               last_slot;
        logic               token_granted;
    } in_item_t;

    typedef struct packed {
        kind_t                kind;
        logic [CHANNEL_W-1:0] channel;
        logic [VALUE_W-1:0]   value;
        logic                 last;
    } out_item_t;

endpackage

FILE: design/dmx_frame_diff_encoder.sv
// ----------------------------------------------------------------------------
// dmx_frame_diff_encoder
// compares each lighting frame with the stored previous frame and reports
// unchanged, dropped, full frame needed, diff entries or an empty diff
// ----------------------------------------------------------------------------
// throughput: one slot per cycle inside a frame (frame store read in the
//   accept cycle, compare and write-back in the following cycle)
// end of frame: input blocked after the last slot until the outcome is issued, then one result
//   per cycle while the entry memory is streamed out and the output is not stalled
// reset: synchronous, active low; no clearing pass, the previous length
//   acts as fill count of the frame store
// ----------------------------------------------------------------------------
module dmx_frame_diff_encoder #(
    parameter int MAX_SLOTS   = 512,
    parameter int MAX_ENTRIES = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [dmxfde_pkg::LIMIT_W-1:0]     cfg_wr_data,
    // slot input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  dmxfde_pkg::in_item_t               s_data,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output dmxfde_pkg::out_item_t              m_data
);
    import dmxfde_pkg::*;

    // widths derived from the store sizes
    localparam int PW  = $clog2(MAX_SLOTS + 1);                  // slot position, holds MAX_SLOTS
    localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1; // frame store address
    localparam int CW  = $clog2(MAX_ENTRIES + 1);                // entry count
    localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [PW-1:0]      SLOTS_MAX   = PW'(MAX_SLOTS);
    localparam logic [CW-1:0]      ENTRIES_MAX = CW'(MAX_ENTRIES);
    localparam logic [LIMIT_W-1:0] ENTRIES_LIM = LIMIT_W'(MAX_ENTRIES);

    // memories: previous frame and buffered diff entries
    logic [VALUE_W-1:0]   frame_mem [MAX_SLOTS];
    logic [CHANNEL_W-1:0] ent_ch_mem [MAX_ENTRIES];
    logic [VALUE_W-1:0]   ent_val_mem [MAX_ENTRIES];

    // registers
    state_t               state_reg, state_next;
    logic [LIMIT_W-1:0]   diff_limit_reg, diff_limit_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [PW-1:0]        prev_len_reg, prev_len_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 limit_hit_reg, limit_hit_next;
    logic                 any_diff_reg, any_diff_next;
    logic                 token_reg, token_next;
    // compare stage
    logic                 st1_valid_reg, st1_valid_next;
    in_item_t             st1_item_reg, st1_item_next;
    logic [PW-1:0]        st1_pos_reg, st1_pos_next;
    logic                 st1_in_range_reg, st1_in_range_next;
    logic [VALUE_W-1:0]   frame_rd_reg;
    // flush
    logic [CW-1:0]        flush_cnt_reg, flush_cnt_next;
    logic [CW-1:0]        flush_idx_reg, flush_idx_next;
    logic                 ent_valid_reg, ent_valid_next;
    logic                 ent_last_reg, ent_last_next;
    logic [CHANNEL_W-1:0] ent_ch_rd_reg;
    logic [VALUE_W-1:0]   ent_val_rd_reg;
    // output register
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg, m_data_next;

    // combinational helpers
    logic                 s_accept;
    logic                 in_range;
    logic [VALUE_W-1:0]   old_value;
    logic                 slot_diff;
    logic                 ent_wr;
    logic [CW-1:0]        count_inc;
    logic [LIMIT_W-1:0]   limit_eff;
    logic                 frame_any;
    logic                 out_free;
    logic                 ent_move;
    logic                 ent_issue;
    out_item_t            single_item;

    // slot can enter in the run state unless a frame end is in the compare stage
    assign s_ready  = (state_reg == ST_RUN) && !(st1_valid_reg && st1_item_reg.last_slot);
    assign s_accept = s_valid && s_ready;
    // slots beyond the store are neither compared nor stored
    assign in_range = (pos_reg < SLOTS_MAX);

    // limit clamped to the entry buffer; zero behaves like one
    assign limit_eff = (diff_limit_reg > ENTRIES_LIM) ? ENTRIES_LIM : diff_limit_reg;

    // old slots past the previous length compare against zero
    assign old_value = (st1_pos_reg < prev_len_reg) ? frame_rd_reg : '0;
    assign slot_diff = st1_valid_reg && st1_in_range_reg &&
                       (st1_item_reg.slot_value != old_value);
    assign ent_wr    = slot_diff && !limit_hit_reg && (count_reg < ENTRIES_MAX);
    assign count_inc = count_reg + CW'(1);

    // a length change counts as a difference too
    assign frame_any = any_diff_reg || (pos_reg != prev_len_reg);

    assign out_free  = !m_valid_reg || m_ready;
    assign ent_move  = (state_reg == ST_FLUSH) && ent_valid_reg && out_free;
    assign ent_issue = (state_reg == ST_FLUSH) && (flush_idx_reg != flush_cnt_reg) &&
                       (!ent_valid_reg || ent_move);

    // single-item outcome of a frame
    always_comb begin
        single_item         = '0;
        single_item.last    = 1'b1;
        if (!frame_any) begin
            single_item.kind = KIND_UNCHANGED;
        end else if (!token_reg) begin
            single_item.kind = KIND_DROPPED;
        end else if (limit_hit_reg) begin
            single_item.kind = KIND_FULL;
        end else begin
            single_item.kind = KIND_EMPTY;
        end
    end

    // next state and datapath control
    always_comb begin
        state_next        = state_reg;
        diff_limit_next   = diff_limit_reg;
        pos_next          = pos_reg;
        prev_len_next     = prev_len_reg;
        count_next        = count_reg;
        limit_hit_next    = limit_hit_reg;
        any_diff_next     = any_diff_reg;
        token_next        = token_reg;
        st1_valid_next    = s_accept;
        st1_item_next     = st1_item_reg;
        st1_pos_next      = st1_pos_reg;
        st1_in_range_next = st1_in_range_reg;
        flush_cnt_next    = flush_cnt_reg;
        flush_idx_next    = flush_idx_reg;
        ent_valid_next    = ent_valid_reg;
        ent_last_next     = ent_last_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        if (cfg_wr_en) begin
            diff_limit_next = cfg_wr_data;
        end

        // accept: capture the slot, frame store read goes out now
        if (s_accept) begin
            st1_item_next     = s_data;
            st1_pos_next      = pos_reg;
            st1_in_range_next = in_range;
            if (in_range) begin
                pos_next = pos_reg + PW'(1);
            end
        end

        // compare stage
        if (slot_diff) begin
            any_diff_next = 1'b1;
        end
        if (ent_wr) begin
            count_next = count_inc;
            if (LIMIT_W'(count_inc) >= limit_eff) begin
                limit_hit_next = 1'b1;
            end
        end

        case (state_reg)
            ST_RUN: begin
                if (st1_valid_reg && st1_item_reg.last_slot) begin
                    token_next = st1_item_reg.token_granted;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (frame_any && token_reg && !limit_hit_reg && (count_reg != '0)) begin
                    // stream the buffered entries
                    flush_cnt_next = count_reg;
                    flush_idx_next = '0;
                    ent_valid_next = 1'b0;
                    state_next     = ST_FLUSH;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = single_item;
                    state_next   = ST_RUN;
                end
                // frame bookkeeping restarts as the decide state is left
                if (state_next != ST_DECIDE) begin
                    prev_len_next  = pos_reg;
                    pos_next       = '0;
                    count_next     = '0;
                    limit_hit_next = 1'b0;
                    any_diff_next  = 1'b0;
                end
            end
            ST_FLUSH: begin
                if (ent_move) begin
                    m_valid_next         = 1'b1;
                    m_data_next.kind     = KIND_ENTRY;
                    m_data_next.channel  = ent_ch_rd_reg;
                    m_data_next.value    = ent_val_rd_reg;
                    m_data_next.last     = ent_last_reg;
                    ent_valid_next       = 1'b0;
                    if (ent_last_reg) begin
                        state_next = ST_RUN;
                    end
                end
                if (ent_issue) begin
                    ent_valid_next = 1'b1;
                    ent_last_next  = (flush_idx_reg + CW'(1)) == flush_cnt_reg;
                    flush_idx_next = flush_idx_reg + CW'(1);
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            diff_limit_reg <= DIFF_LIMIT_RESET;
            pos_reg        <= '0;
            prev_len_reg   <= '0;
            count_reg      <= '0;
            limit_hit_reg  <= 1'b0;
            any_diff_reg   <= 1'b0;
            st1_valid_reg  <= 1'b0;
            ent_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            diff_limit_reg <= diff_limit_next;
            pos_reg        <= pos_next;
            prev_len_reg   <= prev_len_next;
            count_reg      <= count_next;
            limit_hit_reg  <= limit_hit_next;
            any_diff_reg   <= any_diff_next;
            st1_valid_reg  <= st1_valid_next;
            ent_valid_reg  <= ent_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        token_reg        <= token_next;
        st1_item_reg     <= st1_item_next;
        st1_pos_reg      <= st1_pos_next;
        st1_in_range_reg <= st1_in_range_next;
        flush_cnt_reg    <= flush_cnt_next;
        flush_idx_reg    <= flush_idx_next;
        ent_last_reg     <= ent_last_next;
        m_data_reg       <= m_data_next;
    end

    // frame store: read at accept, write back from the compare stage
    always_ff @(posedge aclk) begin
        if (s_accept && in_range) begin
            frame_rd_reg <= frame_mem[pos_reg[AW-1:0]];
        end
        if (st1_valid_reg && st1_in_range_reg) begin
            frame_mem[st1_pos_reg[AW-1:0]] <= st1_item_reg.slot_value;
        end
    end

    // entry buffer: 1-based channel and new value of each change
    always_ff @(posedge aclk) begin
        if (ent_wr) begin
            ent_ch_mem[count_reg[EAW-1:0]]  <= CHANNEL_W'(st1_pos_reg) + CHANNEL_W'(1);
            ent_val_mem[count_reg[EAW-1:0]] <= st1_item_reg.slot_value;
        end
        if (ent_issue) begin
            ent_ch_rd_reg  <= ent_ch_mem[flush_idx_reg[EAW-1:0]];
            ent_val_rd_reg <= ent_val_mem[flush_idx_reg[EAW-1:0]];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: design/dmxfde_checker.sv
// ----------------------------------------------------------------------------
// dmxfde_checker
// port-level checks of the dmx frame diff encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "dmx_frame_diff_encoder_assert.svh"

module dmxfde_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input dmxfde_pkg::in_item_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input dmxfde_pkg::out_item_t m_data
);
    import dmxfde_pkg::*;

    // stalled result transaction holds
    `DFE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // every outcome other than a diff entry is a lone item with zero fields
    `DFE_ASSERT_IMPLY(a_single_item, aclk, aresetn, m_valid && (m_data.kind != KIND_ENTRY), m_data.last && (m_data.channel == '0) && (m_data.value == '0))

    // diff entries carry a 1-based channel
    `DFE_ASSERT_IMPLY(a_entry_channel, aclk, aresetn, m_valid && (m_data.kind == KIND_ENTRY), m_data.channel != '0)

    // input closes right after the last slot of a frame
    `DFE_ASSERT_NEXT(a_frame_end_block, aclk, aresetn, s_valid && s_ready && s_data.last_slot, !s_ready)

endmodule

bind dmx_frame_diff_encoder dmxfde_checker u_dmxfde_checker (.*);

FILE: verif/tb_dmx_frame_diff_encoder.sv
// ----------------------------------------------------------------------------
// tb_dmx_frame_diff_encoder
// self-checking bench: frames are streamed slot by slot, each accepted slot
// transaction updates a behavioral copy of the frame store, and every result
// transaction is checked field by field against the oldest predicted report
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dmx_frame_diff_encoder;

    import dmxfde_pkg::*;

    localparam int MAX_SLOTS    = 512;
    localparam int MAX_ENTRIES  = 64;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 10;    // margin, block is idle once the last report is out
    localparam int STALL_LIMIT  = 2000;  // cycles without any transaction

    // ------------------------------------------------------------------------
    // frame store prediction and expected report queue
    // ------------------------------------------------------------------------
    class diff_report_scoreboard;
        logic [VALUE_W-1:0]   prev_frame [MAX_SLOTS];
        int unsigned          prev_len;
        int unsigned          slot_pos;
        int unsigned          n_changes;
        bit                   at_limit;
        bit                   changed;
        logic [CHANNEL_W-1:0] ent_channel [MAX_ENTRIES];
        logic [VALUE_W-1:0]   ent_value [MAX_ENTRIES];
        logic [LIMIT_W-1:0]   limit_reg;
        out_item_t            expected_reports[$];
        int                   mismatches;
        int                   kind_count [5];

        function new();
            foreach (prev_frame[i]) prev_frame[i] = '0;
            prev_len   = 0;
            slot_pos   = 0;
            n_changes  = 0;
            at_limit   = 0;
            changed    = 0;
            limit_reg  = DIFF_LIMIT_RESET;
            mismatches = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            limit_reg = v;
        endfunction

        function void push_report(kind_t k, logic [CHANNEL_W-1:0] ch,
                                  logic [VALUE_W-1:0] v, logic l);
            out_item_t r;
            r.kind    = k;
            r.channel = ch;
            r.value   = v;
            r.last    = l;
            expected_reports.insert(expected_reports.size(), r);
        endfunction

        function void note_slot(in_item_t it);
            int unsigned        lim;
            logic [VALUE_W-1:0] old;
            lim = (limit_reg > MAX_ENTRIES) ? MAX_ENTRIES : limit_reg;
            if (slot_pos < MAX_SLOTS) begin
                old = (slot_pos < prev_len) ? prev_frame[slot_pos] : '0;
                if (it.slot_value != old) begin
                    changed = 1;
                    if (!at_limit && n_changes < MAX_ENTRIES) begin
                        ent_channel[n_changes] = CHANNEL_W'(slot_pos + 1);
                        ent_value[n_changes]   = it.slot_value;
                        n_changes++;
                        if (n_changes >= lim) at_limit = 1;
                    end
                end
                prev_frame[slot_pos] = it.slot_value;
                slot_pos++;
            end
            if (!it.last_slot) return;
            if (slot_pos != prev_len) changed = 1;
            if (!changed) begin
                push_report(KIND_UNCHANGED, '0, '0, 1'b1);
            end else if (!it.token_granted) begin
                push_report(KIND_DROPPED, '0, '0, 1'b1);
            end else if (at_limit) begin
                push_report(KIND_FULL, '0, '0, 1'b1);
            end else if (n_changes == 0) begin
                push_report(KIND_EMPTY, '0, '0, 1'b1);
            end else begin
                for (int i = 0; i < n_changes; i++)
                    push_report(KIND_ENTRY, ent_channel[i], ent_value[i],
                                (i + 1 == n_changes));
            end
            prev_len  = slot_pos;
            slot_pos  = 0;
            n_changes = 0;
            at_limit  = 0;
            changed   = 0;
        endfunction

        function void check_report(out_item_t got);
            out_item_t want;
            if (expected_reports.size() == 0) begin
                $error("result with nothing pending: kind %0d channel %0d value %0d",
                       got.kind, got.channel, got.value);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            kind_count[int'(want.kind)]++;
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.channel !== want.channel) begin
                $error("channel: expected %0d, actual %0d", want.channel, got.channel);
                mismatches++;
            end
            if (got.value !== want.value) begin
                $error("value: expected %0d, actual %0d", want.value, got.value);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    in_item_t           s_data      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    out_item_t          m_data;

    diff_report_scoreboard sb;

    // idling knobs, written by the stimulus process only
    int                 sender_idle_pct = 0;
    int                 recv_stall_pct  = 0;
    bit                 hold_req        = 0;
    // set by the receiver process once its long hold-off is over
    bit                 hold_done       = 0;

    logic [LIMIT_W-1:0] cur_limit = DIFF_LIMIT_RESET;
    logic [7:0]         frame_q[$];    // frame about to be sent
    logic [7:0]         gen_prev[$];   // last frame sent, as stored by the block
    int                 slots_sent  = 0;
    int                 frames_sent = 0;

    dmx_frame_diff_encoder uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // monitor: transactions are taken at the rising edge, inputs first so a
    // report can never be checked before the slot that causes it is noted
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_slot(s_data);
            if (m_valid && m_ready) sb.check_report(m_data);
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure, plus one long hold-off on request so the
    // block backs up and has to stall the slot input
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1;
            end
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when no transaction moves for too long
    // ------------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb_dmx_frame_diff_encoder NOT OK");
        $finish;
    end

    // append one slot value to the frame being built
    function automatic void add_slot(logic [7:0] v);
        frame_q.insert(frame_q.size(), v);
    endfunction

    // ------------------------------------------------------------------------
    // slot driver; entered and left at a falling edge with the previous slot
    // still offered, so valid is only lowered when a gap really follows
    // ------------------------------------------------------------------------
    task automatic send_slot(logic [7:0] v, logic last, logic tok);
        in_item_t it;
        it.slot_value    = v;
        it.last_slot     = last;
        it.token_granted = tok;
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid = 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_data  = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        slots_sent++;
    endtask

    // token is only meaningful on the last slot, random on the others
    task automatic send_frame(logic tok);
        for (int i = 0; i < frame_q.size(); i++) begin
            if (i == frame_q.size() - 1)
                send_slot(frame_q[i], 1'b1, tok);
            else
                send_slot(frame_q[i], 1'b0, 1'($urandom_range(1)));
        end
        frames_sent++;
        gen_prev = frame_q;
        while (gen_prev.size() > MAX_SLOTS) void'(gen_prev.pop_back());
    endtask

    // stop offering and wait until every predicted report has come out,
    // then give the block time to settle back to its slot state
    task automatic wait_idle();
        s_valid = 1'b0;
        while (sb.expected_reports.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [LIMIT_W-1:0] v);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        sb.set_limit(v);
        cur_limit   = v;
    endtask

    // ------------------------------------------------------------------------
    // random frame: mostly the previous frame with a few edited slots, so
    // unchanged frames and short diffs are common; edit counts cluster
    // around the change limit to hit both sides of it
    // ------------------------------------------------------------------------
    task automatic build_random_frame(output logic tok);
        int len, nmut, r, lim, start;
        lim = (cur_limit > MAX_ENTRIES) ? MAX_ENTRIES : cur_limit;
        if (lim == 0) lim = 1;
        r = $urandom_range(99);
        if (gen_prev.size() == 0 || gen_prev.size() > 100 || r < 20)
            len = $urandom_range(1, 40);
        else if (r < 28)
            len = $urandom_range(60, 100);
        else if (r < 38)
            len = gen_prev.size() + $urandom_range(0, 6) - 3;
        else
            len = gen_prev.size();
        if (len < 1) len = 1;

        frame_q.delete();
        if ($urandom_range(9) == 0) begin
            repeat (len) add_slot(8'($urandom_range(0, 255)));
        end else begin
            for (int i = 0; i < len; i++)
                add_slot((i < gen_prev.size()) ? gen_prev[i] : 8'd0);
        end

        r = $urandom_range(99);
        if (r < 30)      nmut = 0;
        else if (r < 70) nmut = $urandom_range(1, 4);
        else if (r < 90) nmut = lim - 1 + $urandom_range(0, 2);
        else             nmut = $urandom_range(0, len);
        if (nmut > len) nmut = len;

        // contiguous run of edits keeps the positions distinct
        start = $urandom_range(0, len - 1);
        for (int j = 0; j < nmut; j++)
            frame_q[(start + j) % len] ^= 8'($urandom_range(1, 255));
        tok = ($urandom_range(99) < 80);
    endtask

    task automatic run_phase(logic [LIMIT_W-1:0] lim, int idle, int stall, int budget);
        int   n;
        logic tok;
        wait_idle();
        cfg_write(lim);
        sender_idle_pct = idle;
        recv_stall_pct  = stall;
        n = 0;
        while (n < budget) begin
            build_random_frame(tok);
            send_frame(tok);
            n += frame_q.size();
        end
    endtask

    // ------------------------------------------------------------------------
    // back-pressure
    // ------------------------------------------------------------------------
    task automatic run_pressure_phase();
        wait_idle();
        cfg_write(7'd64);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        // receiver stops for a long stretch while dense diffs keep coming
        hold_req = 1;
        repeat (3) begin
            frame_q.delete();
            repeat (30) add_slot(8'($urandom_range(0, 255)));
            send_frame(1'b1);
        end
        // sender waits for every pending report
        wait_idle();

        // back to a short frame: every old slot beyond it is dropped
        frame_q.delete();
        repeat (5) add_slot(8'($urandom_range(0, 255)));
        send_frame(1'b1);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed frames at the reset limit; a single zero slot differs
        // from the empty store by length only
        frame_q = '{8'd0};                       send_frame(1'b1);
        // unchanged is reported even without a token
        frame_q = '{8'd0};                       send_frame(1'b0);
        // a change without a token drops the frame
        frame_q = '{8'd255};                     send_frame(1'b0);
        // the dropped frame still updated the store; slot 2 is past old length
        frame_q = '{8'd7, 8'd255, 8'd0};         send_frame(1'b1);
        // shorter frame, same values: length change only
        frame_q = '{8'd7, 8'd255};               send_frame(1'b1);
        frame_q = '{8'd7, 8'd255};               send_frame(1'b1);

        // limit one: the first change asks for a full frame
        wait_idle();
        cfg_write(7'd1);
        frame_q = '{8'd8, 8'd255};               send_frame(1'b1);
        frame_q = '{8'd8, 8'd255, 8'd0, 8'd0};   send_frame(1'b0);

        // limit zero behaves like one
        wait_idle();
        cfg_write(7'd0);
        frame_q = '{8'd9, 8'd254, 8'd0, 8'd0};   send_frame(1'b1);
        frame_q = '{8'd9, 8'd254, 8'd0, 8'd0};   send_frame(1'b1);

        // random phases: limit, sender idle %, receiver stall %, slot budget
        run_phase(7'd64,  0,  0,  50);
        run_phase(7'd5,   82, 0,  45);
        run_phase(7'd127, 0,  82, 45);
        run_phase(7'd2,   14, 14, 45);
        run_pressure_phase();

        // drain and allow for any stray report after the last one
        wait_idle();
        repeat (2 * DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d slots in %0d frames, limits 0/1/2/5/64/127, long output hold",
                 slots_sent, frames_sent);
        $display("reports: unchanged %0d, entries %0d, empty %0d, full %0d, dropped %0d",
                 sb.kind_count[0], sb.kind_count[1], sb.kind_count[2],
                 sb.kind_count[3], sb.kind_count[4]);
        if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
            $display("tb_dmx_frame_diff_encoder OK");
        end else begin
            $display("tb_dmx_frame_diff_encoder NOT OK");
        end
        $finish;
    end

endmodule
